// File: rtl/core/wrra_pkg.sv
// ----------------------------------------------------------------------------
// wrra_pkg: shared types and constants for the window receiver
// Flag masks, result kinds, controller states and command/status structs.
// ----------------------------------------------------------------------------
package wrra_pkg;

	localparam int unsigned BUF_ENTRIES_DEF = 32;

	localparam logic [15:0] FLAG_SYN   = 16'h0001;
	localparam logic [15:0] FLAG_ACK   = 16'h0002;
	localparam logic [15:0] FLAG_START = 16'h0004;
	localparam logic [15:0] FLAG_DATA  = 16'h0008;
	localparam logic [15:0] FLAG_FIN   = 16'h0010;

	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_SYNACK  = 2'd2;
	localparam logic [1:0] KIND_FINACK  = 2'd3;

	// output register source select
	localparam logic [1:0] OSEL_HDR   = 2'd0; // deliver the captured header
	localparam logic [1:0] OSEL_ENTRY = 2'd1; // deliver the entry just read
	localparam logic [1:0] OSEL_ACK   = 2'd2; // data ACK
	localparam logic [1:0] OSEL_CTRL  = 2'd3; // SYN-ACK or FIN ACK

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_EMIT,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture input header
		logic scan_start;  // restart entry scan
		logic scan_step;   // advance scan one entry
		logic do_start;    // START handling
		logic do_inorder;  // accept header as in-order
		logic do_store;    // store header into free entry
		logic rd_min;      // read smallest entry from memory
		logic pop_min;     // drain read entry
		logic fin_clear;   // FIN: clear used count, end session
		logic out_load;    // load output register
		logic [1:0] out_sel; // one of the OSEL_* sources
		logic out_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic min_found;
		logic min_match;   // min seq equals next_expected
		logic dup;
		logic free_ok;     // free entry exists and room under limit
		logic min_len_nz;
		logic data_phase;
		logic session_over;
		logic seq_eq;
		logic seq_gt;
		logic hdr_len_nz;
		logic [15:0] flags;
		logic out_busy;
	} stat_t;

endpackage

// File: rtl/core/window_receiver_reorder_ack.sv
// ----------------------------------------------------------------------------
// window_receiver_reorder_ack: sliding-window receiver with reorder buffer
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One header is taken at a time; s_tready is high only while the block waits.
// START, SYN, an old DATA header, a header with no meaningful flag and anything
// after FIN need no scan of the entry store. Other DATA headers and FIN scan it
// one entry per cycle through the sequence memory's read port. Each drained
// entry costs one more scan plus a memory read, and an in-order header that
// itself carries payload costs one scan more; FIN drains every stored entry
// the same way.
// Results wait in one output register; a held m_tready stalls the sequence.
module window_receiver_reorder_ack #(
	parameter int unsigned BUFFER_ENTRIES = wrra_pkg::BUF_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [5:0] cfg_wdata,   // buffer_limit
	input  logic s_tvalid,
	output logic s_tready,
	// packet_flags, packet_seq, packet_time, packet_epoch, payload_length,
	// payload_handle
	input  logic [119:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// result_kind, ack_seq, ack_echo_time, ack_epoch, ack_window,
	// deliver_handle, deliver_length
	output logic [111:0] m_tdata,
	output logic m_tlast          // last_of_run
);
	import wrra_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic in_fire;

	// accept a header transfer
	assign in_fire = s_tvalid && s_tready;

	wrra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	wrra_datapath #(.BUFFER_ENTRIES(BUFFER_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_flags(s_tdata[15:0]), .in_seq(s_tdata[47:16]), .in_time(s_tdata[79:48]),
		.in_epoch(s_tdata[87:80]), .in_len(s_tdata[103:88]),
		.in_handle(s_tdata[119:104]), .cmd(cmd), .stat(stat),
		.out_take(m_tvalid && m_tready), .out_valid(m_tvalid),
		.out_data(m_tdata), .out_last(m_tlast)
	);
endmodule

// File: rtl/core/wrra_datapath.sv
// ----------------------------------------------------------------------------
// wrra_datapath: header register, entry store, scan unit and output register
// Scans one entry per cycle for smallest sequence, duplicate and free slot.
// ----------------------------------------------------------------------------
module wrra_datapath #(
	parameter int unsigned BUFFER_ENTRIES = wrra_pkg::BUF_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic [15:0] in_flags,
	input  logic [31:0] in_seq,
	input  logic [31:0] in_time,
	input  logic [7:0] in_epoch,
	input  logic [15:0] in_len,
	input  logic [15:0] in_handle,
	input  wrra_pkg::cmd_t cmd,
	output wrra_pkg::stat_t stat,
	input  logic out_take,
	output logic out_valid,
	output logic [111:0] out_data,
	output logic out_last
);
	import wrra_pkg::*;

	localparam int unsigned IW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(BUFFER_ENTRIES + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(BUFFER_ENTRIES - 1);

	logic [5:0] limit_q;
	logic data_phase_q, session_over_q;
	logic [31:0] next_q;
	logic [7:0] lie_q;
	logic [BUFFER_ENTRIES-1:0] valid_q;
	logic [5:0] used_q;

	logic [15:0] h_flags_q;
	logic [31:0] h_seq_q, h_time_q, at_q;
	logic [7:0] h_epoch_q, ae_q;
	logic [15:0] h_len_q, h_handle_q;

	logic [31:0] seq_mem [BUFFER_ENTRIES];
	logic [71:0] pay_mem [BUFFER_ENTRIES]; // time, epoch, handle, length

	logic [CW-1:0] scan_q;
	logic scan_done_q, min_found_q, dup_q, free_found_q;
	logic [IW-1:0] min_idx_q, free_idx_q;
	logic [31:0] min_seq_q;
	logic [31:0] rd_seq_q;
	logic [71:0] rd_pay_q;

	logic [5:0] eff_limit;
	logic [5:0] window;
	logic [IW-1:0] scan_idx;
	logic hdr_is_data, hdr_is_fin, hdr_is_syn;

	assign scan_idx = scan_q[IW-1:0];
	assign eff_limit = (limit_q > 6'(BUFFER_ENTRIES)) ? 6'(BUFFER_ENTRIES) : limit_q;
	assign window = (used_q >= eff_limit) ? 6'd1 : eff_limit - used_q;
	assign hdr_is_data = (h_flags_q & FLAG_DATA) != 16'd0;
	assign hdr_is_fin = (h_flags_q & FLAG_FIN) != 16'd0;
	assign hdr_is_syn = (h_flags_q & FLAG_SYN) != 16'd0;

	// sequence memory read each scan cycle
	logic [31:0] scan_seq_q;
	logic [IW-1:0] scan_idx_s1;
	logic scan_vld_s1;
	always_ff @(posedge clk) begin
		scan_seq_q <= seq_mem[scan_idx];
		rd_seq_q <= seq_mem[min_idx_q];
		rd_pay_q <= pay_mem[min_idx_q];
		if (cmd.do_store) begin
			seq_mem[free_idx_q] <= h_seq_q;
			pay_mem[free_idx_q] <= {h_time_q, h_epoch_q, h_handle_q, h_len_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 6'd32;
			data_phase_q <= 1'b0;
			session_over_q <= 1'b0;
			next_q <= '0;
			lie_q <= 8'd1;
			valid_q <= '0;
			used_q <= '0;
			scan_q <= '0;
			scan_vld_s1 <= 1'b0;
			scan_done_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
			if (cmd.do_start) begin
				data_phase_q <= 1'b1;
				next_q <= 32'd1;
			end
			if (cmd.do_inorder) begin
				lie_q <= h_epoch_q;
				next_q <= next_q + 32'd1;
			end
			if (cmd.pop_min) begin
				valid_q[min_idx_q] <= 1'b0;
				if (used_q != 6'd0) used_q <= used_q - 6'd1;
				if (!hdr_is_fin || hdr_is_data) begin
					lie_q <= rd_pay_q[39:32];
					next_q <= next_q + 32'd1;
				end
			end
			if (cmd.do_store) begin
				valid_q[free_idx_q] <= 1'b1;
				used_q <= used_q + 6'd1;
			end
			if (cmd.fin_clear) begin
				used_q <= '0;
				session_over_q <= 1'b1;
			end
			// scan pipeline: address issue then compare in the cycle after
			if (cmd.scan_start) begin
				scan_q <= '0;
				scan_vld_s1 <= 1'b0;
				scan_done_q <= 1'b0;
			end else if (cmd.scan_step && !scan_done_q) begin
				scan_vld_s1 <= (scan_q <= LAST_IDX);
				if (scan_q <= LAST_IDX) scan_q <= scan_q + CW'(1);
				else scan_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			min_found_q <= 1'b0;
			dup_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_step && scan_vld_s1) begin
			if (valid_q[scan_idx_s1]) begin
				if (scan_seq_q == h_seq_q) dup_q <= 1'b1;
				if (!min_found_q || scan_seq_q < min_seq_q) begin
					min_found_q <= 1'b1;
					min_seq_q <= scan_seq_q;
					min_idx_q <= scan_idx_s1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q <= scan_idx_s1;
			end
		end
		if (cmd.scan_step) scan_idx_s1 <= scan_idx;
		if (cmd.load) begin
			h_flags_q <= in_flags;
			h_seq_q <= in_seq;
			h_time_q <= in_time;
			h_epoch_q <= in_epoch;
			h_len_q <= in_len;
			h_handle_q <= in_handle;
			at_q <= in_time;
			ae_q <= in_epoch;
		end
		if (cmd.pop_min) begin
			at_q <= rd_pay_q[71:40];
			ae_q <= rd_pay_q[39:32];
		end
		if (cmd.out_load) begin
			out_last <= cmd.out_last;
			case (cmd.out_sel)
				OSEL_HDR: out_data <= {h_len_q, h_handle_q, 6'd0, h_epoch_q, h_time_q,
					h_seq_q, KIND_DELIVER};
				OSEL_ENTRY: out_data <= {rd_pay_q[15:0], rd_pay_q[31:16], 6'd0,
					rd_pay_q[39:32], rd_pay_q[71:40], rd_seq_q, KIND_DELIVER};
				OSEL_ACK: begin
					if (stat.seq_gt || !stat.seq_eq)
						out_data <= {32'd0, window, lie_q, h_time_q, next_q, KIND_ACK};
					else
						out_data <= {32'd0, window, ae_q, at_q, next_q, KIND_ACK};
				end
				default: begin
					if (hdr_is_syn)
						out_data <= {32'd0, eff_limit, h_epoch_q, h_time_q, 32'd0,
							KIND_SYNACK};
					else
						out_data <= {32'd0, 6'd1, h_epoch_q, h_time_q, h_seq_q,
							KIND_FINACK};
				end
			endcase
		end
	end

	// in-order marker survives while next_q advances during the drain
	logic inorder_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inorder_q <= 1'b0;
		else if (cmd.load) inorder_q <= 1'b0;
		else if (cmd.do_inorder) inorder_q <= 1'b1;
	end

	assign stat.scan_done = scan_done_q;
	assign stat.min_found = min_found_q;
	assign stat.min_match = min_seq_q == next_q;
	assign stat.dup = dup_q;
	assign stat.free_ok = free_found_q && (used_q < eff_limit);
	assign stat.min_len_nz = rd_pay_q[15:0] != 16'd0;
	assign stat.data_phase = data_phase_q;
	assign stat.session_over = session_over_q;
	assign stat.seq_eq = inorder_q || (h_seq_q == next_q);
	assign stat.seq_gt = !inorder_q && (h_seq_q > next_q);
	assign stat.hdr_len_nz = h_len_q != 16'd0;
	assign stat.flags = h_flags_q;
	assign stat.out_busy = out_valid && !out_take;
endmodule

// File: rtl/core/wrra_ctrl.sv
// ----------------------------------------------------------------------------
// wrra_ctrl: sequencer for one header
// Orders scan, store, drain and result transfers.
// ----------------------------------------------------------------------------
module wrra_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	output logic in_ready,
	input  wrra_pkg::stat_t stat,
	output wrra_pkg::cmd_t cmd
);
	import wrra_pkg::*;

	// job codes; JOB_NONE in ST_SCAN means data still to be classified
	localparam logic [2:0] JOB_NONE    = 3'd0;
	localparam logic [2:0] JOB_INORDER = 3'd1;
	localparam logic [2:0] JOB_FUTURE  = 3'd2;
	localparam logic [2:0] JOB_OLD     = 3'd3;
	localparam logic [2:0] JOB_FIN     = 3'd4;
	localparam logic [2:0] JOB_SYN     = 3'd5;

	state_t state_q, state_d;
	logic [2:0] job_q, job_d;
	logic hdr_pend_q, hdr_pend_d; // in-order header deliver still owed
	// tracks whether EMIT follows a read (entry result) or the final ack
	logic state_prev_read_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_NONE;
			hdr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q <= job_d;
			hdr_pend_q <= hdr_pend_d;
		end
	end

	logic is_syn, is_start, is_dat, is_fin;
	assign is_syn = |(stat.flags & FLAG_SYN);
	assign is_start = |(stat.flags & FLAG_START);
	assign is_dat = |(stat.flags & FLAG_DATA);
	assign is_fin = |(stat.flags & FLAG_FIN);

	always_comb begin
		state_d = state_q;
		job_d = job_q;
		hdr_pend_d = hdr_pend_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_DONE; // decode next cycle
			ST_DONE: begin
				state_d = ST_IDLE;
				if (stat.session_over) job_d = JOB_NONE;
				else if (is_syn) begin
					job_d = JOB_SYN;
					state_d = ST_EMIT;
				end else if (is_start) job_d = JOB_NONE;
				else if (is_dat || is_fin) begin
					state_d = ST_SCAN;
					job_d = is_dat ? JOB_NONE : JOB_FIN;
				end
			end
			ST_SCAN: if (job_q == JOB_NONE) begin
				// classify data after phase setup
				if (stat.seq_eq) begin
					job_d = JOB_INORDER;
					hdr_pend_d = stat.hdr_len_nz;
				end else if (stat.seq_gt) job_d = JOB_FUTURE;
				else begin
					job_d = JOB_OLD;
					state_d = ST_EMIT;
				end
			end else if (stat.scan_done) begin
				if (job_q == JOB_FUTURE) state_d = ST_EMIT;
				else if (stat.min_found && (job_q == JOB_FIN || stat.min_match))
					state_d = ST_READ;
				else state_d = ST_EMIT;
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: if (!stat.out_busy) begin
				if (hdr_pend_q) begin
					hdr_pend_d = 1'b0;
					state_d = ST_SCAN;
				end else if (job_q == JOB_INORDER || job_q == JOB_FIN) begin
					if (state_prev_read_q) state_d = ST_SCAN;
					else state_d = ST_IDLE;
				end else state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_prev_read_q <= 1'b0;
		else if (state_q == ST_READ) state_prev_read_q <= 1'b1;
		else if (state_q == ST_EMIT && !stat.out_busy) state_prev_read_q <= 1'b0;
	end

	always_comb begin
		cmd = '0;
		in_ready = state_q == ST_IDLE;
		cmd.load = in_fire;
		case (state_q)
			ST_DONE: begin
				if (!stat.session_over && !is_syn &&
					(is_start || ((is_dat || is_fin) && !stat.data_phase)))
					cmd.do_start = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_SCAN: begin
				if (job_q == JOB_NONE) begin
					cmd.do_inorder = stat.seq_eq;
					cmd.scan_start = 1'b1;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.scan_done && job_q == JOB_FUTURE && !stat.dup && stat.free_ok)
						cmd.do_store = 1'b1;
				end
			end
			ST_READ: cmd.rd_min = 1'b1;
			ST_EMIT: if (!stat.out_busy) begin
				if (hdr_pend_q) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = OSEL_HDR;
					cmd.scan_start = 1'b1;
				end else if (state_prev_read_q) begin
					cmd.pop_min = 1'b1;
					cmd.out_load = stat.min_len_nz;
					cmd.out_sel = OSEL_ENTRY;
					cmd.scan_start = 1'b1;
				end else begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_sel = (job_q == JOB_FIN || job_q == JOB_SYN) ? OSEL_CTRL : OSEL_ACK;
					cmd.fin_clear = job_q == JOB_FIN;
				end
			end
			default: ;
		endcase
	end
endmodule
